// ===== rtl/xyctr_pkg.sv =====
// shared constants, codes and control structs for the xy color transition ramp
// no dependencies; used by every other file of the block
package xyctr_pkg;

	localparam int COORD_W = 16;
	localparam int FRAC_W  = 8;
	localparam int ACC_W   = COORD_W + FRAC_W;
	localparam int STEP_W  = ACC_W + 1;
	localparam int SUM_W   = ACC_W + 2;
	localparam int CNT_W   = $clog2(ACC_W);

	localparam logic [COORD_W-1:0] ENDLESS_TICKS = 16'hFFFF;
	localparam logic [COORD_W-1:0] XY_MAX_RESET  = 16'hFEFF;
	localparam logic [COORD_W-1:0] XY_MIN_RESET  = 16'h0000;
	localparam logic [ACC_W:0]     ROUND_BIAS    = 25'd127;

	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic CFG_XY_MIN = 1'b0;
	localparam logic CFG_XY_MAX = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_RES  = 4'b1000
	} state_t;

	typedef struct packed {
		logic move;
		logic update;
	} lane_ctrl_t;

	typedef struct packed {
		logic step_done;
	} lane_stat_t;

endpackage

// ===== rtl/xyctr_if.sv =====
// valid/ready channel interfaces for command and result beats
// depends on xyctr_pkg for field widths
interface xyctr_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [xyctr_pkg::COORD_W-1:0] target_x;
	logic [xyctr_pkg::COORD_W-1:0] target_y;
	logic [xyctr_pkg::COORD_W-1:0] transition_time;

	modport source (output valid, output operation, output target_x, output target_y,
		output transition_time, input ready);
	modport sink (input valid, input operation, input target_x, input target_y,
		input transition_time, output ready);
endinterface

interface xyctr_res_if;
	logic                          valid;
	logic                          ready;
	logic [xyctr_pkg::COORD_W-1:0] current_x;
	logic [xyctr_pkg::COORD_W-1:0] current_y;
	logic [xyctr_pkg::COORD_W-1:0] ticks_left;
	logic                          transition_active;

	modport source (output valid, output current_x, output current_y, output ticks_left,
		output transition_active, input ready);
	modport sink (input valid, input current_x, input current_y, input ticks_left,
		input transition_active, output ready);
endinterface

// ===== rtl/xyctr_div.sv =====
// serial restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on xyctr_pkg for widths
module xyctr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [xyctr_pkg::ACC_W-1:0]   dividend,
	input  logic [xyctr_pkg::COORD_W-1:0] divisor,
	output logic                          done,
	output logic [xyctr_pkg::ACC_W-1:0]   quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [xyctr_pkg::CNT_W-1:0]   cnt_q;
	logic [xyctr_pkg::COORD_W-1:0] div_q;
	logic [xyctr_pkg::COORD_W-1:0] rem_q;
	logic [xyctr_pkg::ACC_W-1:0]   quo_q;
	logic [xyctr_pkg::COORD_W:0]   rem_sh;
	logic [xyctr_pkg::COORD_W:0]   rem_sub;
	logic                          fits;

	always_comb begin
		rem_sh  = {rem_q, quo_q[xyctr_pkg::ACC_W-1]};
		rem_sub = rem_sh - {1'b0, div_q};
		fits    = (rem_sh >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == xyctr_pkg::CNT_W'(xyctr_pkg::ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops out
			rem_q <= fits ? rem_sub[xyctr_pkg::COORD_W-1:0] : rem_sh[xyctr_pkg::COORD_W-1:0];
			quo_q <= {quo_q[xyctr_pkg::ACC_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/xyctr_lane.sv =====
// one coordinate axis: accumulator, step, rounded coordinate and its step divider
// depends on xyctr_pkg and xyctr_div
module xyctr_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  xyctr_pkg::lane_ctrl_t         ctrl,
	input  logic [xyctr_pkg::COORD_W-1:0] target,
	input  logic [xyctr_pkg::COORD_W-1:0] ticks,
	input  logic [xyctr_pkg::COORD_W-1:0] xy_min,
	input  logic [xyctr_pkg::COORD_W-1:0] xy_max,
	output xyctr_pkg::lane_stat_t         stat,
	output logic [xyctr_pkg::COORD_W-1:0] now
);

	logic [xyctr_pkg::ACC_W-1:0]         accum_q;
	logic signed [xyctr_pkg::STEP_W-1:0] step_q;
	logic [xyctr_pkg::COORD_W-1:0]       now_q;
	logic                                neg_q;

	logic [xyctr_pkg::COORD_W:0]         diff;
	logic [xyctr_pkg::COORD_W:0]         mag;
	logic                                div_done;
	logic [xyctr_pkg::ACC_W-1:0]         quo;

	logic signed [xyctr_pkg::SUM_W-1:0]  sum;
	logic [xyctr_pkg::COORD_W:0]         sum_int;
	logic                                step_pos;
	logic                                step_neg;
	logic [xyctr_pkg::ACC_W-1:0]         acc_nxt;
	logic [xyctr_pkg::ACC_W:0]           rnd;
	logic [xyctr_pkg::COORD_W-1:0]       now_nxt;

	always_comb begin
		diff = {1'b0, target} - {1'b0, now_q};
		mag  = diff[xyctr_pkg::COORD_W] ? -diff : diff;
	end

	xyctr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.move),
		.dividend ({mag[xyctr_pkg::COORD_W-1:0], xyctr_pkg::FRAC_W'(0)}),
		.divisor  (ticks),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		sum      = $signed({2'b00, accum_q}) + $signed({step_q[xyctr_pkg::STEP_W-1], step_q});
		sum_int  = sum[xyctr_pkg::SUM_W-2:xyctr_pkg::FRAC_W];
		step_neg = step_q[xyctr_pkg::STEP_W-1];
		step_pos = !step_neg && (step_q != '0);
		if (step_pos && (sum_int > {1'b0, xy_max})) begin
			acc_nxt = {xy_max, xyctr_pkg::FRAC_W'(0)};
		end else if (step_neg && (sum[xyctr_pkg::SUM_W-1] || (sum_int < {1'b0, xy_min}))) begin
			acc_nxt = {xy_min, xyctr_pkg::FRAC_W'(0)};
		end else begin
			acc_nxt = sum[xyctr_pkg::ACC_W-1:0];
		end
		// round to nearest with ties down, only while ramping upward, saturate on carry out
		rnd = {1'b0, acc_nxt} + xyctr_pkg::ROUND_BIAS;
		if (step_pos) begin
			now_nxt = rnd[xyctr_pkg::ACC_W] ? '1 : rnd[xyctr_pkg::ACC_W-1:xyctr_pkg::FRAC_W];
		end else begin
			now_nxt = acc_nxt[xyctr_pkg::ACC_W-1:xyctr_pkg::FRAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			step_q  <= '0;
			now_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			if (ctrl.move) begin
				accum_q <= {now_q, xyctr_pkg::FRAC_W'(0)};
				neg_q   <= diff[xyctr_pkg::COORD_W];
			end else if (ctrl.update) begin
				accum_q <= acc_nxt;
				now_q   <= now_nxt;
			end
			if (div_done) begin
				step_q <= neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
			end
		end
	end

	assign stat.step_done = div_done;
	assign now            = now_q;

endmodule

// ===== rtl/xy_color_transition_ramp_top.sv =====
// top level of the xy color transition ramp: control, tick counter, limits, result register
// depends on xyctr_pkg, xyctr_if and xyctr_lane
//
// Ramps a color point (x, y) toward a target in 16.8 fixed point. A move beat sets a
// per-tick step for each axis, (target - current) * 256 / time truncated toward zero
// (time 0 counts as 1), and applies one update; a tick beat applies one update while
// ticks remain (65535 never counts down). Each axis is a lane with its own serial
// divider, and both lanes run side by side; the result stage merges them with the tick
// count. A move runs divide, update and result; a tick runs update and result, or only
// result with no ticks left. One beat is worked on at a time, and the next command is
// taken while the previous result still waits downstream. Limits are written through
// cfg_we/cfg_index/cfg_data by the user only while idle; the block does not enforce it.
module xy_color_transition_ramp_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [xyctr_pkg::COORD_W-1:0] cfg_data,
	xyctr_cmd_if.sink                     cmd,
	xyctr_res_if.source                   res
);

	xyctr_pkg::state_t             state_q;
	logic [xyctr_pkg::COORD_W-1:0] xy_min_q;
	logic [xyctr_pkg::COORD_W-1:0] xy_max_q;
	logic [xyctr_pkg::COORD_W-1:0] ticks_q;
	logic                          res_valid_q;
	logic [xyctr_pkg::COORD_W-1:0] res_x_q;
	logic [xyctr_pkg::COORD_W-1:0] res_y_q;
	logic [xyctr_pkg::COORD_W-1:0] res_ticks_q;
	logic                          res_active_q;

	logic                          accept;
	logic                          res_load;
	logic [xyctr_pkg::COORD_W-1:0] ticks_in;
	xyctr_pkg::lane_ctrl_t         lane_ctrl;
	xyctr_pkg::lane_stat_t         stat_x;
	xyctr_pkg::lane_stat_t         stat_y;
	logic [xyctr_pkg::COORD_W-1:0] now_x;
	logic [xyctr_pkg::COORD_W-1:0] now_y;

	always_comb begin
		cmd.ready        = (state_q == xyctr_pkg::ST_IDLE);
		accept           = cmd.valid && cmd.ready;
		ticks_in         = (cmd.transition_time == '0) ? xyctr_pkg::COORD_W'(1)
			: cmd.transition_time;
		lane_ctrl.move   = accept && (cmd.operation == xyctr_pkg::OP_MOVE);
		lane_ctrl.update = (state_q == xyctr_pkg::ST_UPD);
		res_load         = (state_q == xyctr_pkg::ST_RES) && (!res_valid_q || res.ready);
	end

	xyctr_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.target (cmd.target_x),
		.ticks  (ticks_in),
		.xy_min (xy_min_q),
		.xy_max (xy_max_q),
		.stat   (stat_x),
		.now    (now_x)
	);

	xyctr_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.target (cmd.target_y),
		.ticks  (ticks_in),
		.xy_min (xy_min_q),
		.xy_max (xy_max_q),
		.stat   (stat_y),
		.now    (now_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= xyctr_pkg::ST_IDLE;
			xy_min_q <= xyctr_pkg::XY_MIN_RESET;
			xy_max_q <= xyctr_pkg::XY_MAX_RESET;
			ticks_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					xyctr_pkg::CFG_XY_MIN: xy_min_q <= cfg_data;
					xyctr_pkg::CFG_XY_MAX: xy_max_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				xyctr_pkg::ST_IDLE: begin
					if (accept) begin
						if (cmd.operation == xyctr_pkg::OP_MOVE) begin
							ticks_q <= ticks_in;
							state_q <= xyctr_pkg::ST_DIV;
						end else if (ticks_q != '0) begin
							state_q <= xyctr_pkg::ST_UPD;
						end else begin
							state_q <= xyctr_pkg::ST_RES;
						end
					end
				end
				xyctr_pkg::ST_DIV: begin
					// both lanes divide by the same count, so they finish together
					if (stat_x.step_done && stat_y.step_done) begin
						state_q <= xyctr_pkg::ST_UPD;
					end
				end
				xyctr_pkg::ST_UPD: begin
					// one count per update, endless never counts down
					if (ticks_q != xyctr_pkg::ENDLESS_TICKS) begin
						ticks_q <= ticks_q - 1'b1;
					end
					state_q <= xyctr_pkg::ST_RES;
				end
				xyctr_pkg::ST_RES: begin
					if (res_load) begin
						state_q <= xyctr_pkg::ST_IDLE;
					end
				end
				default: state_q <= xyctr_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_x_q      <= now_x;
			res_y_q      <= now_y;
			res_ticks_q  <= ticks_q;
			res_active_q <= (ticks_q != '0);
		end
	end

	assign res.valid             = res_valid_q;
	assign res.current_x         = res_x_q;
	assign res.current_y         = res_y_q;
	assign res.ticks_left        = res_ticks_q;
	assign res.transition_active = res_active_q;

endmodule
